[sv/fixed_block_pool_allocator_assert.svh]
// ---------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Clocked assertion shorthands shared by the checker of the block.
// ---------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define FBPA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define FBPA_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define FBPA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[sv/fbpa_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fixed block pool allocator package
// Sizes, codes and beat types shared by the allocator modules.
// ---------------------------------------------------------------------------
package fbpa_pkg;

  // Pool geometry. ALIGN_BYTES must be a power of two.
  localparam int MAX_BLOCKS   = 64;
  localparam int ALIGN_BYTES  = 4;
  localparam int HEADER_BYTES = 4;

  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 17;
  localparam int STRIDE_W = SIZE_W + 2;
  localparam int PROD_W   = IDX_W + STRIDE_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [STRIDE_W-1:0] ALIGN_MASK = STRIDE_W'(ALIGN_BYTES - 1);

  // Opcodes.
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Result status codes.
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_EMPTY    = 2'd1;
  localparam logic [1:0] STS_ALL_FREE = 2'd2;
  localparam logic [1:0] STS_RANGE    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [IDX_W-1:0] block_index;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  granted_index;
    logic [ADDR_W-1:0] data_address;
    logic [CNT_W-1:0]  free_blocks;
  } out_beat_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } link_wr_t;

endpackage

[sv/fbpa_link_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fixed block pool allocator link memory
// One write port and one registered read port holding the free list links.
// ---------------------------------------------------------------------------
module fbpa_link_ram (
  input  logic                     clk,
  input  fbpa_pkg::link_wr_t       wr,
  input  logic                     rd_en,
  input  logic [fbpa_pkg::IDX_W-1:0] rd_addr,
  output logic [fbpa_pkg::IDX_W-1:0] rd_data
);

  logic [fbpa_pkg::IDX_W-1:0] mem [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::IDX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/fbpa_addr_gen.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fixed block pool allocator address generator
// Payload address of a block from the base, the aligned stride and the index.
// ---------------------------------------------------------------------------
module fbpa_addr_gen (
  input  logic [fbpa_pkg::ADDR_W-1:0] base,
  input  logic [fbpa_pkg::SIZE_W-1:0] block_size,
  input  logic [fbpa_pkg::IDX_W-1:0]  idx,
  output logic [fbpa_pkg::ADDR_W-1:0] addr
);

  logic [fbpa_pkg::STRIDE_W-1:0] size_up;
  logic [fbpa_pkg::STRIDE_W-1:0] stride;
  logic [fbpa_pkg::PROD_W-1:0]   offset;

  always_comb begin
    // Round the payload up to the alignment, then add the header.
    size_up = fbpa_pkg::STRIDE_W'(block_size) + fbpa_pkg::ALIGN_MASK;
    stride  = (size_up & ~fbpa_pkg::ALIGN_MASK) + fbpa_pkg::STRIDE_W'(fbpa_pkg::HEADER_BYTES);
    offset  = fbpa_pkg::PROD_W'(idx) * fbpa_pkg::PROD_W'(stride);
    addr    = base + fbpa_pkg::ADDR_W'(offset) + fbpa_pkg::ADDR_W'(fbpa_pkg::HEADER_BYTES);
  end

endmodule

[sv/fixed_block_pool_allocator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fixed block pool allocator
// LIFO free list of equal-size blocks with a fresh-block pointer behind it.
// ---------------------------------------------------------------------------
// An input beat is handled in the idle state and then the execute state: in
// the cycle it is accepted the link memory is read at the current list head,
// and in the execute state the read data is used to pop the list (or the
// memory is written to push a freed block), the bookkeeping registers are
// updated and the result is loaded into the output register. The registered
// read port of the link memory is why the execute state is needed. A result
// that has not yet been taken stalls the execute state only. The next input
// beat is still accepted while that result waits, but it then holds in the
// execute state, and keeps the input side closed, until the output register
// has been emptied. The link memory needs no clearing after reset: an entry
// is only ever used after a free has written it, so the block is ready for
// input beats straight out of reset. Configuration writes take effect on the
// next beat and are meant to be made while the block is idle.
// ---------------------------------------------------------------------------
module fixed_block_pool_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fbpa_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fbpa_pkg::out_beat_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]     cfg_wdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  localparam logic [fbpa_pkg::CNT_W-1:0] CNT_MAX = fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS);
  localparam logic [fbpa_pkg::CNT_W-1:0] CNT_ONE = fbpa_pkg::CNT_W'(1);

  // Sequencer and the beat being worked on.
  logic                        state_r, state_nxt;
  fbpa_pkg::in_beat_t          beat_r;

  // Free list bookkeeping. The list is empty exactly when its length is zero.
  logic [fbpa_pkg::IDX_W-1:0]  head_r, head_nxt;
  logic [fbpa_pkg::CNT_W-1:0]  len_r, len_nxt;
  logic [fbpa_pkg::CNT_W-1:0]  fresh_r, fresh_nxt;
  logic [fbpa_pkg::CNT_W-1:0]  free_r, free_nxt;

  // Configuration registers.
  logic [fbpa_pkg::ADDR_W-1:0] base_r;
  logic [fbpa_pkg::SIZE_W-1:0] bsize_r;
  logic [fbpa_pkg::CNT_W-1:0]  bcount_r;

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  fbpa_pkg::out_beat_t         out_data_r;
  fbpa_pkg::out_beat_t         result;

  logic                        accept;
  logic                        out_free;
  logic                        commit;
  logic [fbpa_pkg::CNT_W-1:0]  eff_cnt;
  logic                        got;
  logic [fbpa_pkg::IDX_W-1:0]  grant_idx;
  logic [fbpa_pkg::ADDR_W-1:0] grant_addr;
  logic [fbpa_pkg::IDX_W-1:0]  link_rd;
  fbpa_pkg::link_wr_t          link_wr;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign commit    = (state_r == S_EXEC) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A block count of zero behaves as one, and counts above the pool size are
  // clipped to the pool size.
  always_comb begin
    if (bcount_r == '0) begin
      eff_cnt = CNT_ONE;
    end else if (bcount_r > CNT_MAX) begin
      eff_cnt = CNT_MAX;
    end else begin
      eff_cnt = bcount_r;
    end
  end

  // The link of the current head is read on acceptance, so it is ready in the
  // execute cycle. The head cannot change between the read and its use.
  fbpa_link_ram u_link_ram (
    .clk     (clk),
    .wr      (link_wr),
    .rd_en   (accept),
    .rd_addr (head_r),
    .rd_data (link_rd)
  );

  fbpa_addr_gen u_addr_gen (
    .base       (base_r),
    .block_size (bsize_r),
    .idx        (grant_idx),
    .addr       (grant_addr)
  );

  // Execute step: resolve the beat against the bookkeeping and link read.
  always_comb begin
    head_nxt     = head_r;
    len_nxt      = len_r;
    fresh_nxt    = fresh_r;
    free_nxt     = free_r;
    got          = 1'b0;
    grant_idx    = '0;
    link_wr.en   = 1'b0;
    link_wr.addr = beat_r.block_index;
    link_wr.data = (len_r != '0) ? head_r : '0;
    result.status = fbpa_pkg::STS_OK;

    case (beat_r.opcode)
      fbpa_pkg::OP_INIT: begin
        head_nxt  = '0;
        len_nxt   = '0;
        fresh_nxt = '0;
        free_nxt  = eff_cnt;
      end
      fbpa_pkg::OP_ALLOC: begin
        if (free_r != '0 && len_r != '0) begin
          // Pop the most recently freed block. When this empties the list
          // the head is left as it is, since nothing will use it.
          got       = 1'b1;
          grant_idx = head_r;
          len_nxt   = len_r - CNT_ONE;
          if (len_r != CNT_ONE) begin
            head_nxt = link_rd;
          end
        end else if (free_r != '0 && fresh_r < eff_cnt) begin
          got       = 1'b1;
          grant_idx = fresh_r[fbpa_pkg::IDX_W-1:0];
          fresh_nxt = fresh_r + CNT_ONE;
        end
        if (got) begin
          free_nxt = free_r - CNT_ONE;
        end else begin
          result.status = fbpa_pkg::STS_EMPTY;
        end
      end
      fbpa_pkg::OP_FREE: begin
        if ({1'b0, beat_r.block_index} >= eff_cnt) begin
          result.status = fbpa_pkg::STS_RANGE;
        end else if (free_r >= eff_cnt) begin
          result.status = fbpa_pkg::STS_ALL_FREE;
        end else begin
          link_wr.en = commit;
          head_nxt   = beat_r.block_index;
          len_nxt    = len_r + CNT_ONE;
          free_nxt   = free_r + CNT_ONE;
        end
      end
      default: begin
      end
    endcase

    result.granted_index = grant_idx;
    result.data_address  = got ? grant_addr : '0;
    result.free_blocks   = free_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      len_r       <= '0;
      fresh_r     <= '0;
      free_r      <= CNT_MAX;
      base_r      <= '0;
      bsize_r     <= fbpa_pkg::SIZE_W'(64);
      bcount_r    <= CNT_MAX;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        head_r  <= head_nxt;
        len_r   <= len_nxt;
        fresh_r <= fresh_nxt;
        free_r  <= free_nxt;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          fbpa_pkg::CFG_BASE:  base_r   <= cfg_wdata;
          fbpa_pkg::CFG_SIZE:  bsize_r  <= cfg_wdata[fbpa_pkg::SIZE_W-1:0];
          fbpa_pkg::CFG_COUNT: bcount_r <= cfg_wdata[fbpa_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      beat_r <= in_data;
    end
    if (commit) begin
      out_data_r <= result;
    end
  end

endmodule

[sv/fbpa_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fixed block pool allocator checker
// Port-level assertions on the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "fixed_block_pool_allocator_assert.svh"

module fbpa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fbpa_pkg::out_beat_t out_data
);

  // A stalled result beat must not change.
  `FBPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

  // Only a successful allocation reports an index or an address.
  `FBPA_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && out_data.status != fbpa_pkg::STS_OK, out_data.granted_index == '0 && out_data.data_address == '0, "failed beat carries a grant")

  // The free count never exceeds the pool.
  `FBPA_ASSERT_ALWAYS(a_free_bound, clk, rst_n, !out_valid || out_data.free_blocks <= 7'(fbpa_pkg::MAX_BLOCKS), "free count above pool size")

  // An accepted input beat moves the block into the execute state, which closes the input side.
  `FBPA_ASSERT_NEXT(a_two_cycle, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted in back-to-back cycles")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
